@@ rtl/core/sbrp_pkg.sv @@
// Package for the STUN binding response parser.
// Types, status codes and protocol constants shared by the engine and the top level.
package sbrp_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned END_W   = 17;
    localparam int unsigned CAP_W   = 48;
    localparam int unsigned TXID_W  = 96;
    localparam int unsigned CFG_W   = 64;

    localparam logic [15:0] HDR_BYTES        = 16'd20;
    localparam logic [15:0] BINDING_RESPONSE = 16'h0101;
    localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
    localparam logic [15:0] ATTR_MAPPED      = 16'h0001;
    localparam logic [7:0]  FAMILY_IPV4      = 8'h01;
    localparam logic [31:0] COOKIE           = 32'h2112A442;
    localparam logic [15:0] COOKIE_HIGH      = 16'h2112;
    localparam logic [CAP_W-1:0] COOKIE_MASK = {COOKIE_HIGH, COOKIE};

    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic CFG_TXID_UPPER = 1'b0;
    localparam logic CFG_TXID_LOWER = 1'b1;

    typedef enum logic [2:0] {
        STAT_FOUND       = 3'd0,
        STAT_SHORT       = 3'd1,
        STAT_NOT_BINDING = 3'd2,
        STAT_BAD_COOKIE  = 3'd3,
        STAT_TXID        = 3'd4,
        STAT_NO_ADDR     = 3'd5
    } status_t;

    localparam status_t VERDICT_NONE = STAT_FOUND;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       last;
    } sbrp_item_t;

    typedef struct packed {
        logic        was_xor;
        logic [15:0] port;
        logic [31:0] ip;
        status_t     status;
    } sbrp_result_t;

endpackage

@@ rtl/core/stun_binding_response_parser.sv @@
// STUN binding response parser: input register, parse engine, output register.
// Results are registered in the output register; throughput: one item per cycle while m_tready allows.
// The input register refills in the same cycle it drains, so only m_tready stalls the path.
// Reset (aresetn low, synchronous) clears pending, datagram state, both item valid flags
// and the transaction id registers.
// Depends on sbrp_pkg and sbrp_engine.
module stun_binding_response_parser #(
    parameter int unsigned MAX_DGRAM_BYTES = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic [0:0]                    s_tuser,   // [0] operation
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,   // [2:0] status, [34:3] mapped_ip,
                                                     // [50:35] mapped_port, [51] was_xor
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [sbrp_pkg::CFG_W-1:0]    cfg_wdata
);
    import sbrp_pkg::*;

    logic [31:0]   txid_upper_reg;
    logic [63:0]   txid_lower_reg;
    logic          in_valid_reg,  in_valid_next;
    sbrp_item_t    in_item_reg;
    logic          out_valid_reg, out_valid_next;
    sbrp_result_t  out_res_reg;
    logic          out_free;
    logic          fire;
    logic          eng_valid;
    sbrp_result_t  eng_res;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire && eng_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            txid_upper_reg <= '0;
            txid_lower_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_TXID_UPPER: txid_upper_reg <= cfg_wdata[31:0];
                    CFG_TXID_LOWER: txid_lower_reg <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{op: s_tuser[0], data: s_tdata, last: s_tlast};
        end
        if (fire && eng_valid) begin
            out_res_reg <= eng_res;
        end
    end

    sbrp_engine #(
        .MAX_DGRAM_BYTES(MAX_DGRAM_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(fire),
        .item      (in_item_reg),
        .txid      ({txid_upper_reg, txid_lower_reg}),
        .res_valid (eng_valid),
        .res       (eng_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.was_xor, out_res_reg.port,
                       out_res_reg.ip, out_res_reg.status};

endmodule

@@ rtl/core/sbrp_engine.sv @@
// Per-item parse engine: datagram state registers and the single-pass update logic.
// Depends on sbrp_pkg.
module sbrp_engine #(
    parameter int unsigned MAX_DGRAM_BYTES = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  sbrp_pkg::sbrp_item_t          item,
    input  logic [sbrp_pkg::TXID_W-1:0]   txid,
    output logic                          res_valid,
    output sbrp_pkg::sbrp_result_t        res
);
    import sbrp_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_DGRAM_BYTES);

    logic              pending_reg,  pending_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [END_W-1:0]  attr_end_reg, attr_end_next;
    logic [31:0]       shift_reg,    shift_next;
    logic [15:0]       kind_reg,     kind_next;
    logic [15:0]       alen_reg,     alen_next;
    logic [POS_W-1:0]  voff_reg,     voff_next;
    logic [CAP_W-1:0]  cap_reg,      cap_next;
    status_t           verdict_reg,  verdict_next;
    logic              found_reg,    found_next;

    logic [POS_W-1:0]  p;
    logic [POS_W-1:0]  pos_after;
    logic [POS_W-1:0]  vi;
    logic [7:0]        b;
    logic [31:0]       shift_new;
    logic [3:0]        tx_idx;
    logic [7:0]        exp_byte;
    logic [17:0]       total;
    logic [1:0]        pad;
    logic              stop;
    status_t           status;

    always_comb begin
        pending_next  = pending_reg;
        pos_next      = pos_reg;
        attr_end_next = attr_end_reg;
        shift_next    = shift_reg;
        kind_next     = kind_reg;
        alen_next     = alen_reg;
        voff_next     = voff_reg;
        cap_next      = cap_reg;
        verdict_next  = verdict_reg;
        found_next    = found_reg;
        res_valid     = 1'b0;
        res           = '0;
        p             = pos_reg;
        pos_after     = pos_reg;
        vi            = voff_reg - POS_W'(4);
        b             = item.data;
        shift_new     = {shift_reg[23:0], item.data};
        tx_idx        = 4'(pos_reg - POS_W'(8));
        exp_byte      = 8'(txid >> {4'd11 - tx_idx, 3'b000});
        total         = '0;
        pad           = '0;
        stop          = 1'b0;
        status        = STAT_NO_ADDR;

        if (item_valid) begin
            if (item.op == OP_ARM) begin
                pending_next = 1'b1;
            end else begin
                if (pos_reg < MAX_POS) begin
                    if (p < HDR_BYTES) begin
                        shift_next = shift_new;
                        if (p == POS_W'(1) && shift_new[15:0] != BINDING_RESPONSE &&
                            verdict_next == VERDICT_NONE) begin
                            verdict_next = STAT_NOT_BINDING;
                        end
                        if (p == POS_W'(3)) begin
                            attr_end_next = END_W'(HDR_BYTES) + {1'b0, shift_new[15:0]};
                        end
                        if (p == POS_W'(7) && shift_new != COOKIE &&
                            verdict_next == VERDICT_NONE) begin
                            verdict_next = STAT_BAD_COOKIE;
                        end
                        if (p >= POS_W'(8) && exp_byte != b && verdict_next == VERDICT_NONE) begin
                            verdict_next = STAT_TXID;
                        end
                        if (p == POS_W'(19)) begin
                            if (!pending_reg && verdict_next == VERDICT_NONE) begin
                                verdict_next = STAT_TXID;
                            end
                            if (verdict_next != VERDICT_NONE) begin
                                attr_end_next = '0;
                            end
                        end
                    end else if (!found_reg && {1'b0, p} < attr_end_reg) begin
                        if (voff_reg < POS_W'(4)) begin
                            unique case (voff_reg[1:0])
                                2'd0: kind_next = {b, 8'h00};
                                2'd1: kind_next = {kind_reg[15:8], b};
                                2'd2: alen_next = {b, 8'h00};
                                2'd3: begin
                                    alen_next = {alen_reg[15:8], b};
                                    if ({2'b00, p} + 18'd1 + {2'b00, alen_next} >
                                        {1'b0, attr_end_reg}) begin
                                        attr_end_next = '0;
                                        stop          = 1'b1;
                                    end
                                end
                            endcase
                        end else if (vi < alen_reg) begin
                            if (vi == POS_W'(1) && b != FAMILY_IPV4) begin
                                kind_next = '0;
                            end
                            if (vi >= POS_W'(2) && vi <= POS_W'(7)) begin
                                cap_next = {cap_reg[CAP_W-9:0], b};
                            end
                            if ({1'b0, vi} + 17'd1 == {1'b0, alen_reg} && alen_reg >= 16'd8 &&
                                (kind_next == ATTR_XOR_MAPPED || kind_next == ATTR_MAPPED)) begin
                                if (kind_next == ATTR_XOR_MAPPED) begin
                                    cap_next = cap_next ^ COOKIE_MASK;
                                end
                                found_next   = 1'b1;
                                pending_next = 1'b0;
                                stop         = 1'b1;
                            end
                        end
                        if (!stop) begin
                            pad   = 2'(~alen_next[1:0] + 2'd1);
                            total = 18'd4 + {2'b00, alen_next} + {16'b0, pad};
                            voff_next = ({2'b00, voff_reg} + 18'd1 >= total) ?
                                        '0 : voff_reg + POS_W'(1);
                        end
                    end
                    pos_after = p + POS_W'(1);
                end
                pos_next = pos_after;

                if (item.last) begin
                    if (pos_after < HDR_BYTES) begin
                        status = STAT_SHORT;
                    end else if (verdict_next != VERDICT_NONE) begin
                        status = verdict_next;
                    end else if (found_next) begin
                        status = STAT_FOUND;
                    end else begin
                        status = STAT_NO_ADDR;
                    end
                    res_valid  = 1'b1;
                    res.status = status;
                    if (status == STAT_FOUND) begin
                        res.ip      = cap_next[31:0];
                        res.port    = cap_next[47:32];
                        res.was_xor = (kind_next == ATTR_XOR_MAPPED);
                    end
                    pos_next      = '0;
                    attr_end_next = '0;
                    shift_next    = '0;
                    kind_next     = '0;
                    alen_next     = '0;
                    voff_next     = '0;
                    cap_next      = '0;
                    verdict_next  = VERDICT_NONE;
                    found_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= 1'b0;
            pos_reg      <= '0;
            attr_end_reg <= '0;
            shift_reg    <= '0;
            kind_reg     <= '0;
            alen_reg     <= '0;
            voff_reg     <= '0;
            cap_reg      <= '0;
            verdict_reg  <= VERDICT_NONE;
            found_reg    <= 1'b0;
        end else begin
            pending_reg  <= pending_next;
            pos_reg      <= pos_next;
            attr_end_reg <= attr_end_next;
            shift_reg    <= shift_next;
            kind_reg     <= kind_next;
            alen_reg     <= alen_next;
            voff_reg     <= voff_next;
            cap_reg      <= cap_next;
            verdict_reg  <= verdict_next;
            found_reg    <= found_next;
        end
    end

    a_found_no_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> verdict_reg == VERDICT_NONE)
        else $error("address found in a datagram with a header fault");

    a_find_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(found_reg) |-> !pending_reg)
        else $error("request still pending after an address was found");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_POS)
        else $error("byte position ran past the datagram limit");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> item_valid && item.op == OP_BYTE && item.last)
        else $error("result raised without a final datagram byte");

endmodule

@@ verif/stun_response_checker.sv @@
`timescale 1ns / 1ps
// Checker for the STUN binding response parser: watches the item, result and register
// ports, predicts one result per datagram and compares it field by field. Needs sbrp_pkg.
module stun_response_checker #(
    parameter int unsigned MAX_DGRAM_BYTES = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic [0:0]                   s_tuser,   // [0] operation
    input  logic                         s_tlast,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [55:0]                  m_tdata,   // [2:0] status, [34:3] mapped_ip,
                                                    // [50:35] mapped_port, [51] was_xor
    input  logic                         cfg_wr_en,
    input  logic                         cfg_addr,
    input  logic [sbrp_pkg::CFG_W-1:0]   cfg_wdata,
    output int unsigned                  fail_count,
    output int unsigned                  awaiting
);
    import sbrp_pkg::*;

    logic          req_pending;
    int unsigned   pos;
    int unsigned   walk_end;
    logic [31:0]   hdr_shift;
    logic [15:0]   kind;
    logic [15:0]   alen;
    int unsigned   attr_off;
    logic [47:0]   addr_word;
    status_t       first_fault;
    logic          have_addr;
    logic [31:0]   id_upper;
    logic [63:0]   id_lower;
    sbrp_result_t  predicted_results[$];

    task automatic clear_datagram();
        pos         = 0;
        walk_end    = 0;
        hdr_shift   = '0;
        kind        = '0;
        alen        = '0;
        attr_off    = 0;
        addr_word   = '0;
        first_fault = VERDICT_NONE;
        have_addr   = 1'b0;
    endtask

    task automatic note_fault(input status_t code);
        if (first_fault == VERDICT_NONE) first_fault = code;
    endtask

    task automatic take_header(input int unsigned p, input logic [7:0] b);
        logic [7:0] want;
        hdr_shift = {hdr_shift[23:0], b};
        if (p == 1 && hdr_shift[15:0] != BINDING_RESPONSE) note_fault(STAT_NOT_BINDING);
        if (p == 3) walk_end = 32'(HDR_BYTES) + 32'(hdr_shift[15:0]);
        if (p == 7 && hdr_shift != COOKIE) note_fault(STAT_BAD_COOKIE);
        if (p >= 8 && p <= 11) begin
            want = id_upper[8*(11-p) +: 8];
            if (want != b) note_fault(STAT_TXID);
        end
        if (p >= 12 && p <= 19) begin
            want = id_lower[8*(19-p) +: 8];
            if (want != b) note_fault(STAT_TXID);
        end
        if (p == 19) begin
            if (!req_pending) note_fault(STAT_TXID);
            if (first_fault != VERDICT_NONE) walk_end = 0;
        end
    endtask

    task automatic take_attr(input int unsigned p, input logic [7:0] b);
        int unsigned off;
        int unsigned vi;
        int unsigned span;
        logic        stop;
        off  = attr_off;
        stop = 1'b0;
        if (off < 4) begin
            case (off)
                0: kind = {b, 8'h00};
                1: kind[7:0] = b;
                2: alen = {b, 8'h00};
                default: begin
                    alen[7:0] = b;
                    if (p + 1 + alen > walk_end) begin
                        walk_end = 0;
                        stop = 1'b1;
                    end
                end
            endcase
        end else begin
            vi = off - 4;
            if (vi < alen) begin
                if (vi == 1 && b != FAMILY_IPV4) kind = '0;
                if (vi >= 2 && vi <= 7) addr_word = {addr_word[39:0], b};
                if (vi + 1 == alen && alen >= 8 &&
                    (kind == ATTR_XOR_MAPPED || kind == ATTR_MAPPED)) begin
                    if (kind == ATTR_XOR_MAPPED) addr_word ^= COOKIE_MASK;
                    have_addr   = 1'b1;
                    req_pending = 1'b0;
                    stop        = 1'b1;
                end
            end
        end
        if (!stop) begin
            span     = 4 + alen + ((4 - (alen & 3)) & 3);
            attr_off = (off + 1 >= span) ? 0 : off + 1;
        end
    endtask

    task automatic parse_datagram_item(input logic op, input logic [7:0] b, input logic last);
        sbrp_result_t res;
        if (op == OP_ARM) begin
            req_pending = 1'b1;
        end else begin
            if (pos < MAX_DGRAM_BYTES) begin
                if (pos < HDR_BYTES) take_header(pos, b);
                else if (!have_addr && pos < walk_end) take_attr(pos, b);
                pos++;
            end
            if (last) begin
                res = '0;
                if (pos < HDR_BYTES) res.status = STAT_SHORT;
                else if (first_fault != VERDICT_NONE) res.status = first_fault;
                else res.status = have_addr ? STAT_FOUND : STAT_NO_ADDR;
                if (res.status == STAT_FOUND) begin
                    res.ip      = addr_word[31:0];
                    res.port    = addr_word[47:32];
                    res.was_xor = (kind == ATTR_XOR_MAPPED);
                end
                predicted_results.push_back(res);
                clear_datagram();
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input logic [55:0] word);
        sbrp_result_t got;
        sbrp_result_t want;
        got = word[51:0];
        if (predicted_results.size() == 0) begin
            $display("%0t: result %0h with none expected", $time, word);
            fail_count++;
        end else begin
            want = predicted_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("mapped_ip", want.ip, got.ip);
            compare_field("mapped_port", want.port, got.port);
            compare_field("was_xor", want.was_xor, got.was_xor);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            req_pending = 1'b0;
            id_upper    = '0;
            id_lower    = '0;
            fail_count  = 0;
            clear_datagram();
            predicted_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_TXID_UPPER) id_upper = cfg_wdata[31:0];
                else id_lower = cfg_wdata;
            end
            if (s_tvalid && s_tready) parse_datagram_item(s_tuser[0], s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_result(m_tdata);
        end
        awaiting <= predicted_results.size();
    end

endmodule

@@ verif/tb_stun_binding_response_parser.sv @@
`timescale 1ns / 1ps
// Top of the STUN binding response parser testbench: clock, reset, register writes and
// datagram traffic, directed then random. Needs sbrp_pkg, the parser and stun_response_checker.
module tb_stun_binding_response_parser;
    import sbrp_pkg::*;

    localparam int unsigned DGRAM_LIMIT  = 2048;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam logic [15:0] MSG_BINDING_REQUEST = 16'h0001;
    localparam logic [15:0] MSG_OTHER           = 16'h0111;
    localparam logic [15:0] ATTR_SOFTWARE       = 16'h8022;
    localparam logic [7:0]  FAMILY_IPV6         = 8'h02;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic [0:0]        s_tuser;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [55:0]       m_tdata;
    logic              cfg_wr_en;
    logic              cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    int unsigned       fail_count;
    int unsigned       awaiting;

    int unsigned       cycle_count = 0;
    int unsigned       lost_results = 0;
    int unsigned       bytes_sent = 0;
    bit                gaps_on = 1'b1;
    logic [95:0]       cur_id = '0;
    logic [7:0]        frame[$];

    stun_binding_response_parser #(.MAX_DGRAM_BYTES(DGRAM_LIMIT)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    stun_response_checker #(.MAX_DGRAM_BYTES(DGRAM_LIMIT)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .awaiting(awaiting)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (gaps_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic push_item(input logic op, input logic [7:0] b, input logic last);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= op;
        s_tdata    <= b;
        s_tlast    <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_frame(input bit arm_first, input int arm_at);
        int i;
        if (arm_first) push_item(OP_ARM, 8'($urandom), 1'($urandom));
        for (i = 0; i < frame.size(); i++) begin
            if (i == arm_at) push_item(OP_ARM, 8'($urandom), 1'($urandom));
            push_item(OP_BYTE, frame[i], i == frame.size() - 1);
            bytes_sent++;
        end
    endtask

    task automatic add_attr(input logic [15:0] kind, input logic [15:0] alen,
                            input logic [7:0] family);
        int unsigned body;
        int unsigned i;
        body = (32'(alen) + 3) / 4 * 4;
        frame.push_back(kind[15:8]);
        frame.push_back(kind[7:0]);
        frame.push_back(alen[15:8]);
        frame.push_back(alen[7:0]);
        for (i = 0; i < body; i++) frame.push_back(i == 1 ? family : 8'($urandom));
    endtask

    task automatic add_header(input logic [15:0] mtype, input logic [15:0] decl,
                              input logic [31:0] cookie, input logic [95:0] id);
        logic [159:0] hdr;
        int           i;
        hdr = {mtype, decl, cookie, id};
        for (i = 0; i < 20; i++) frame.push_front(hdr[8*i +: 8]);
    endtask

    task automatic good_frame(input logic [15:0] kind);
        frame.delete();
        add_attr(kind, 16'd8, FAMILY_IPV4);
        add_header(BINDING_RESPONSE, 16'(frame.size()), COOKIE, cur_id);
    endtask

    task automatic trim_frame(input int unsigned n);
        while (frame.size() > n) void'(frame.pop_back());
    endtask

    task automatic set_txid(input logic [31:0] hi, input logic [63:0] lo);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_TXID_UPPER;
        cfg_wdata <= {32'($urandom), hi};
        @(posedge aclk);
        cfg_addr  <= CFG_TXID_LOWER;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_id = {hi, lo};
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (awaiting != 0) begin
            $display("%0t: %0d results never arrived", $time, awaiting);
            lost_results++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_frame();
        int unsigned n;
        logic [15:0] kind;
        logic [15:0] alen;
        logic [15:0] decl;
        logic [15:0] mtype;
        logic [7:0]  family;
        logic [31:0] cookie;
        logic [95:0] id;
        int          arm_at;
        frame.delete();
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 40);
            repeat (n) frame.push_back(8'($urandom));
        end else begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: kind = ATTR_XOR_MAPPED;
                    3, 4, 5: kind = ATTR_MAPPED;
                    6:       kind = ATTR_SOFTWARE;
                    default: kind = 16'($urandom);
                endcase
                family = ($urandom_range(0, 7) == 0) ? 8'($urandom) : FAMILY_IPV4;
                alen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 24)) : 16'd8;
                add_attr(kind, alen, family);
                if ($urandom_range(0, 15) == 0)
                    repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
            end
            decl   = 16'(frame.size());
            mtype  = BINDING_RESPONSE;
            cookie = COOKIE;
            id     = cur_id;
            case ($urandom_range(0, 19))
                0: decl = 16'($urandom_range(0, decl));
                1: decl = decl + 16'($urandom_range(1, 40));
                2: decl = 16'($urandom);
                3: mtype = mtype ^ (16'd1 << $urandom_range(0, 15));
                4: cookie = cookie ^ (32'd1 << $urandom_range(0, 31));
                5: id = id ^ (96'd1 << $urandom_range(0, 95));
                default: ;
            endcase
            add_header(mtype, decl, cookie, id);
            case ($urandom_range(0, 9))
                0: trim_frame($urandom_range(1, frame.size()));
                1: repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
                default: ;
            endcase
        end
        arm_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, frame.size() - 1) : -1;
        send_frame($urandom_range(0, 9) != 0, arm_at);
    endtask

    task automatic random_phase(input int unsigned n_bytes, input int unsigned n_frames);
        int unsigned start;
        int unsigned frames;
        start  = bytes_sent;
        frames = 0;
        while (bytes_sent - start < n_bytes || frames < n_frames) begin
            random_frame();
            frames++;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_TXID_UPPER;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        good_frame(ATTR_XOR_MAPPED);
        send_frame(1'b0, -1);
        good_frame(ATTR_XOR_MAPPED);
        send_frame(1'b1, -1);
        good_frame(ATTR_MAPPED);
        send_frame(1'b0, 10);
        good_frame(ATTR_XOR_MAPPED);
        send_frame(1'b0, 25);
        good_frame(ATTR_MAPPED);
        send_frame(1'b1, -1);

        frame.delete();
        repeat (7) frame.push_back(8'($urandom));
        send_frame(1'b1, -1);
        frame.delete();
        frame.push_back(8'hFF);
        send_frame(1'b0, -1);

        frame.delete();
        add_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(MSG_OTHER, 16'(frame.size()), COOKIE, cur_id);
        send_frame(1'b1, -1);
        trim_frame(12);
        send_frame(1'b1, -1);
        frame.delete();
        add_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(BINDING_RESPONSE, 16'(frame.size()), COOKIE ^ 32'h80, cur_id);
        send_frame(1'b1, -1);
        frame.delete();
        add_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(BINDING_RESPONSE, 16'(frame.size()), COOKIE, cur_id ^ 96'h1);
        send_frame(1'b1, -1);
        frame.delete();
        add_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(MSG_BINDING_REQUEST, 16'(frame.size()), ~COOKIE, cur_id);
        send_frame(1'b1, -1);

        frame.delete();
        add_attr(ATTR_SOFTWARE, 16'd5, FAMILY_IPV4);
        add_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(BINDING_RESPONSE, 16'(frame.size()), COOKIE, cur_id);
        send_frame(1'b1, -1);
        frame.delete();
        add_attr(ATTR_XOR_MAPPED, 16'd20, FAMILY_IPV6);
        add_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(BINDING_RESPONSE, 16'(frame.size()), COOKIE, cur_id);
        send_frame(1'b1, -1);
        frame.delete();
        add_attr(ATTR_XOR_MAPPED, 16'd4, FAMILY_IPV4);
        add_attr(ATTR_MAPPED, 16'd8, 8'h00);
        add_header(BINDING_RESPONSE, 16'(frame.size()), COOKIE, cur_id);
        send_frame(1'b1, -1);
        frame.delete();
        add_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(BINDING_RESPONSE, 16'd8, COOKIE, cur_id);
        send_frame(1'b1, -1);
        good_frame(ATTR_XOR_MAPPED);
        trim_frame(frame.size() - 2);
        send_frame(1'b1, -1);
        frame.delete();
        frame.push_back(ATTR_XOR_MAPPED[15:8]);
        frame.push_back(ATTR_XOR_MAPPED[7:0]);
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        repeat (8) frame.push_back(8'($urandom));
        add_header(BINDING_RESPONSE, 16'hFFFF, COOKIE, cur_id);
        send_frame(1'b1, -1);
        frame.delete();
        add_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4);
        add_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4);
        add_header(BINDING_RESPONSE, 16'(frame.size()), COOKIE, cur_id);
        send_frame(1'b1, -1);
        drain();

        set_txid('1, '1);
        random_phase(120, 4);
        drain();
        set_txid($urandom, {$urandom, $urandom});
        random_phase(120, 4);
        drain();
        set_txid('0, {$urandom, $urandom});
        random_phase(120, 4);
        drain();
        set_txid($urandom, '0);
        random_phase(120, 4);
        drain();
        gaps_on = 1'b0;
        set_txid($urandom, {$urandom, $urandom});
        random_phase(120, 4);
        drain();

        if (fail_count == 0 && lost_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
